// ----- src/kmpm_pkg.sv -----
// ----------------------------------------------------------------------------
// kmpm_pkg
// Shared types and constants of the KMP pattern matcher: word layouts of
// the text and result channels, field widths and register indexes.
// ----------------------------------------------------------------------------
package kmpm_pkg;

    localparam int CHAR_W    = 7;   // text and pattern character width
    localparam int PAT_W     = 56;  // packed pattern register width
    localparam int LEN_W     = 4;   // pattern length register width
    localparam int START_W   = 16;  // reported match start width
    localparam int CFG_IDX_W = 4;   // register index width on the config port
    localparam int CFG_W     = 56;  // config write data width

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd1;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              first_char;
        logic              last_char;
    } kmpm_in_t;

    typedef struct packed {
        logic               match_found;
        logic [START_W-1:0] match_start;
        logic               no_match;
    } kmpm_out_t;

endpackage

// ----- src/kmpm_step.sv -----
// ----------------------------------------------------------------------------
// kmpm_step
// One automaton transition. The failure chain of the current state is given
// as a mask; the next state is one past the highest chain position whose
// pattern character equals the symbol, or zero when none does.
// ----------------------------------------------------------------------------
module kmpm_step #(
    parameter int MAX_PATTERN   = 8,
    parameter int ALPHABET_SIZE = 128,
    parameter int STATE_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic [MAX_PATTERN-1:0]      chain,
    input  logic [kmpm_pkg::PAT_W-1:0]  pattern,
    input  logic [kmpm_pkg::CHAR_W-1:0] sym,
    output logic [STATE_W-1:0]          next_state
);
    import kmpm_pkg::*;

    logic sym_ok;

    // symbols outside the alphabet match nothing
    assign sym_ok = ({1'b0, sym} < (CHAR_W + 1)'(ALPHABET_SIZE));

    // later (higher) chain positions take priority
    always_comb begin
        next_state = '0;
        for (int r = 0; r < MAX_PATTERN; r++) begin
            if (chain[r] && sym_ok && (pattern[r*CHAR_W +: CHAR_W] == sym)) begin
                next_state = STATE_W'(r + 1);
            end
        end
    end

endmodule

// ----- src/kmp_dfa_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// kmp_dfa_pattern_matcher
// First-occurrence search of a configured pattern in a character stream,
// following the Knuth-Morris-Pratt automaton.
// ----------------------------------------------------------------------------
// A result word is registered and appears in the cycle after its text word
// is accepted. Throughput: one word per cycle while the result side keeps
// up and no rebuild runs. A config write that names a known register starts
// a table rebuild that holds s_ready and cfg_ready low until the failure
// chains of states 1 to len_eff-1 are rebuilt. Reset is synchronous, active
// low; after reset the block is ready at once with pattern 0 and length 1.
// ----------------------------------------------------------------------------
module kmp_dfa_pattern_matcher #(
    parameter int MAX_PATTERN   = 8,
    parameter int ALPHABET_SIZE = 128,
    parameter int INDEX_BITS    = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // text words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  kmpm_pkg::kmpm_in_t            s_data,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output kmpm_pkg::kmpm_out_t           m_data,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kmpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kmpm_pkg::CFG_W-1:0]    cfg_data
);
    import kmpm_pkg::*;

    localparam int STATE_W = $clog2(MAX_PATTERN + 1);
    localparam int PIDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // The automaton table is held as failure chains: chain_reg[j] has a bit
    // set for every state on the fallback path from state j (j included).
    // A transition is then the highest chain entry whose pattern character
    // matches, plus one. chain_reg[0] is just state 0.
    logic [PAT_W-1:0]       pattern_reg;
    logic [LEN_W-1:0]       length_reg;
    logic [MAX_PATTERN-1:0] chain_reg [MAX_PATTERN];

    // rebuild sequencer: walks j = 1 .. length-1, tracking the restart state
    logic                   bld_busy_reg;
    logic [STATE_W-1:0]     bld_idx_reg;
    logic [PIDX_W-1:0]      bld_prev_reg;

    // per-text search state
    logic [STATE_W-1:0]     state_reg;
    logic [INDEX_BITS-1:0]  idx_reg;
    logic                   found_reg;

    // result register
    logic                   m_valid_reg;
    kmpm_out_t              m_data_reg;

    // ------------------------------------------------------------------
    // Combinational
    // ------------------------------------------------------------------
    logic                   s_fire;
    logic                   cfg_fire;
    logic                   cfg_known;
    logic [STATE_W-1:0]     len_eff;
    logic [STATE_W-1:0]     s_cur;
    logic [STATE_W-1:0]     s_eff;
    logic [PIDX_W-1:0]      rd_addr;
    logic [MAX_PATTERN-1:0] chain_rd;
    logic [CHAR_W-1:0]      step_sym;
    logic [STATE_W-1:0]     step_out;
    logic                   found_cur;
    logic [INDEX_BITS-1:0]  idx_cur;
    logic                   hit;
    logic                   found_next;
    logic [STATE_W-1:0]     state_next;
    logic [INDEX_BITS-1:0]  idx_next;
    logic [INDEX_BITS+START_W-1:0] idx_wide;
    logic [START_W-1:0]     idx16;
    kmpm_out_t              res_next;
    logic                   bld_step;

    assign s_ready   = !bld_busy_reg && (!m_valid_reg || m_ready);
    assign cfg_ready = !bld_busy_reg;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == REG_PATTERN_CHARS) ||
                       (cfg_index == REG_PATTERN_LENGTH);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // zero length acts as one, oversize as MAX_PATTERN
    always_comb begin
        if (length_reg == '0) begin
            len_eff = STATE_W'(1);
        end else if (length_reg > LEN_W'(MAX_PATTERN)) begin
            len_eff = STATE_W'(MAX_PATTERN);
        end else begin
            len_eff = length_reg[STATE_W-1:0];
        end
    end

    // start of text clears state, index and found mark first
    assign s_cur     = s_data.first_char ? '0 : state_reg;
    assign found_cur = s_data.first_char ? 1'b0 : found_reg;
    assign idx_cur   = s_data.first_char ? '0 : idx_reg;
    // a state left out of range by a length change restarts at zero
    assign s_eff     = (s_cur >= len_eff) ? '0 : s_cur;

    // the transition unit is shared: rebuild and search never overlap
    assign rd_addr  = bld_busy_reg ? bld_prev_reg : s_eff[PIDX_W-1:0];
    assign chain_rd = chain_reg[rd_addr];
    assign step_sym = bld_busy_reg ?
                      pattern_reg[bld_idx_reg[PIDX_W-1:0]*CHAR_W +: CHAR_W] :
                      s_data.text_char;

    kmpm_step #(
        .MAX_PATTERN   (MAX_PATTERN),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .STATE_W       (STATE_W)
    ) u_step (
        .chain      (chain_rd),
        .pattern    (pattern_reg),
        .sym        (step_sym),
        .next_state (step_out)
    );

    // once found, the automaton freezes until the next start of text
    assign hit        = !found_cur && (step_out == len_eff);
    assign found_next = found_cur || hit;
    assign state_next = found_cur ? s_cur : step_out;
    assign idx_next   = (idx_cur == {INDEX_BITS{1'b1}}) ? idx_cur :
                        idx_cur + INDEX_BITS'(1);

    // start index is taken modulo 2^16 from the (possibly saturated) index
    assign idx_wide = {{START_W{1'b0}}, idx_cur};
    assign idx16    = idx_wide[START_W-1:0];

    always_comb begin
        res_next.match_found = hit;
        res_next.match_start = hit ? (idx16 + START_W'(1) - START_W'(len_eff)) : '0;
        res_next.no_match    = s_data.last_char && !found_next;
    end

    assign bld_step = bld_busy_reg && (bld_idx_reg < len_eff);

    // ------------------------------------------------------------------
    // Configuration and rebuild
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg  <= '0;
            length_reg   <= LEN_W'(1);
            bld_busy_reg <= 1'b0;
            bld_idx_reg  <= '0;
            bld_prev_reg <= '0;
            chain_reg[0] <= MAX_PATTERN'(1);
        end else begin
            if (cfg_fire && cfg_known) begin
                if (cfg_index == REG_PATTERN_CHARS) begin
                    pattern_reg <= cfg_data[PAT_W-1:0];
                end else begin
                    length_reg <= cfg_data[LEN_W-1:0];
                end
                bld_busy_reg <= 1'b1;
                bld_idx_reg  <= STATE_W'(1);
                bld_prev_reg <= '0;
            end else if (bld_step) begin
                chain_reg[bld_idx_reg[PIDX_W-1:0]] <=
                    (MAX_PATTERN'(1) << bld_idx_reg) | chain_rd;
                // next restart state; a foreign pattern character gives zero
                bld_prev_reg <= step_out[PIDX_W-1:0];
                bld_idx_reg  <= bld_idx_reg + STATE_W'(1);
            end else if (bld_busy_reg) begin
                bld_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Search state and result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                idx_reg     <= idx_next;
                found_reg   <= found_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_text_in_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        bld_busy_reg |-> !s_fire)
        else $error("text word taken during table rebuild");

    a_found_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.match_found && m_data_reg.no_match))
        else $error("match and no_match reported together");

    a_found_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && hit) |=> (found_reg && m_data_reg.match_found))
        else $error("match not recorded");

    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.match_found) |-> (m_data_reg.match_start == '0))
        else $error("match_start set without a match");

    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= STATE_W'(MAX_PATTERN))
        else $error("automaton state out of range");

endmodule
